// ----- hw/rtl/bat_pkg.sv -----
// Shared types, CORDIC constants and a helper function for the bulge arc tessellator.
`timescale 1ns / 1ps
package bat_pkg;

	localparam int ITERS     = 31;
	localparam int ANG_W     = 34;
	localparam int MAX_STEPS = 36;
	localparam int STEP_W    = 6;
	localparam int BEND_W    = 24;
	localparam int TRIG_W    = 34;

	typedef logic signed [ANG_W-1:0] ang_t;
	typedef logic signed [TRIG_W-1:0] trig_t;

	localparam logic signed [63:0] GAIN_Q30 = 64'sd652032874;
	localparam logic signed [63:0] PI_Q30   = 64'sd3373259426;
	localparam logic signed [63:0] ONE_Q30  = 64'sd1073741824;

	// Arctangent table, atan(2^-i) in Q30.
	function automatic ang_t atan_tab(input logic [4:0] i);
		logic signed [63:0] v;
		begin
			case (i)
				5'd0:  v = 64'sd843314857;
				5'd1:  v = 64'sd497837829;
				5'd2:  v = 64'sd263043837;
				5'd3:  v = 64'sd133525159;
				5'd4:  v = 64'sd67021687;
				5'd5:  v = 64'sd33543516;
				5'd6:  v = 64'sd16775851;
				5'd7:  v = 64'sd8388437;
				5'd8:  v = 64'sd4194283;
				5'd9:  v = 64'sd2097149;
				5'd10: v = 64'sd1048576;
				5'd11: v = 64'sd524288;
				5'd12: v = 64'sd262144;
				5'd13: v = 64'sd131072;
				5'd14: v = 64'sd65536;
				5'd15: v = 64'sd32768;
				5'd16: v = 64'sd16384;
				5'd17: v = 64'sd8192;
				5'd18: v = 64'sd4096;
				5'd19: v = 64'sd2048;
				5'd20: v = 64'sd1024;
				5'd21: v = 64'sd512;
				5'd22: v = 64'sd256;
				5'd23: v = 64'sd128;
				5'd24: v = 64'sd64;
				5'd25: v = 64'sd32;
				5'd26: v = 64'sd16;
				5'd27: v = 64'sd8;
				5'd28: v = 64'sd4;
				5'd29: v = 64'sd2;
				5'd30: v = 64'sd1;
				default: v = 64'sd0;
			endcase
			atan_tab = v[ANG_W-1:0];
		end
	endfunction

	typedef enum logic [1:0] {
		CORDIC_VECTOR = 2'd0,
		CORDIC_ROTATE = 2'd1
	} cordic_mode_t;

endpackage

// ----- hw/rtl/bat_if.sv -----
// Valid/ready channel interfaces for the tessellator.
`timescale 1ns / 1ps
interface bat_in_if #(parameter int COORD_WIDTH = 48);
	logic valid;
	logic ready;
	logic mode;
	logic start_req;
	logic signed [COORD_WIDTH-1:0] px;
	logic signed [COORD_WIDTH-1:0] py;
	logic signed [COORD_WIDTH-1:0] pz;
	logic signed [23:0] bend;
	modport source (output valid, mode, start_req, px, py, pz, bend, input ready);
	modport sink (input valid, mode, start_req, px, py, pz, bend, output ready);
endinterface

interface bat_out_if #(parameter int COORD_WIDTH = 48);
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] ox;
	logic signed [COORD_WIDTH-1:0] oy;
	logic signed [COORD_WIDTH-1:0] oz;
	logic run_end;
	modport source (output valid, ox, oy, oz, run_end, input ready);
	modport sink (input valid, ox, oy, oz, run_end, output ready);
endinterface

// ----- hw/rtl/bulge_arc_tessellator.sv -----
// Top level of the bulge arc tessellator: vertex state, sequencer and point arithmetic.
//
//  channel  dir  fields                          request
//  in       in   mode start_req px py pz bend    one vertex or close
//  out      out  ox oy oz run_end                one emitted point
//
// A vertex with no arc goes straight to its emit state. An arc segment first computes atan,
// sin(2q) and the step count, then for each interior point runs two CORDIC passes, four
// divisions and a multiply-accumulate over four terms of five slices each (four of 16 bits,
// a top one of 8 bits). The shared CORDIC unit and the bit-serial divider do most of the work.
// in.ready is high only while the sequencer is idle; a stalled out channel holds the
// point and pauses the sequencer. Reset clears the vertex state and the sequencer.
`timescale 1ns / 1ps
module bulge_arc_tessellator #(
	parameter int COORD_WIDTH  = 48,
	parameter int ARC_STEP_DEG = 10
) (
	input logic clk,
	input logic arst_n,
	bat_in_if.sink    in,
	bat_out_if.source out
);
	localparam int CW = COORD_WIDTH;
	localparam logic signed [63:0] STEP_ANG =
		(64'(ARC_STEP_DEG) * bat_pkg::PI_Q30 + 64'sd90) / 64'sd180;
	localparam int NW = 72;
	localparam int PW = 128;

	typedef enum logic [4:0] {
		S_IDLE, S_ATAN_GO, S_ATAN, S_SIN2_GO, S_SIN2, S_CNT, S_PT_GO,
		S_A1_DIV, S_SA1_GO, S_SA1, S_SA2_GO, S_SA2, S_U_GO, S_U,
		S_V_GO, S_V, S_T_DIV, S_MAC, S_EMIT, S_VTX
	} state_t;

	state_t st_q;
	logic signed [CW-1:0] prev_x_q, prev_y_q, prev_z_q, first_x_q, first_y_q, first_z_q;
	logic signed [CW-1:0] x0_q, y0_q, z0_q, x1_q, y1_q, z1_q;
	logic signed [23:0] prev_bend_q, bend_q;
	logic have_prev_q, close_q;
	bat_pkg::ang_t q2_q, a1_q;
	bat_pkg::trig_t sv_q, sa1_q, ca2_q, sa2_q;
	logic signed [bat_pkg::ANG_W+1:0] mag_q;
	logic [bat_pkg::STEP_W-1:0] steps_q, k_q;
	logic signed [NW-1:0] u_q, v_q, t_q;
	logic [1:0] mac_q;
	logic [2:0] slice_q;
	logic signed [PW-1:0] acc_x_q, acc_y_q, acc_z_q;
	logic signed [CW-1:0] ox_q, oy_q, oz_q;
	logic ovalid_q, oend_q;

	logic c_start, c_done, d_start, d_done;
	bat_pkg::cordic_mode_t c_mode;
	bat_pkg::ang_t c_angle, c_z;
	bat_pkg::trig_t c_sin, c_cos;
	logic signed [NW-1:0] d_num, d_quo;
	logic signed [35:0] d_den;

	bat_cordic u_cordic (
		.clk, .arst_n, .start(c_start), .mode(c_mode), .bend(bend_q), .angle(c_angle),
		.done(c_done), .z_out(c_z), .sin_out(c_sin), .cos_out(c_cos)
	);

	bat_divider #(.NW(NW), .DW(36)) u_div (
		.clk, .arst_n, .start(d_start), .num(d_num), .den(d_den), .done(d_done), .quo(d_quo)
	);

	always_comb begin
		c_start = 1'b0;
		c_mode  = bat_pkg::CORDIC_ROTATE;
		c_angle = q2_q;
		d_start = 1'b0;
		d_num   = '0;
		d_den   = 36'sd1;
		case (st_q)
			S_ATAN_GO: begin c_start = 1'b1; c_mode = bat_pkg::CORDIC_VECTOR; end
			S_SIN2_GO: begin c_start = 1'b1; c_angle = q2_q; end
			S_PT_GO: begin
				d_start = 1'b1;
				d_num = NW'(q2_q) * NW'(signed'({1'b0, k_q}));
				d_den = 36'(signed'({1'b0, steps_q}));
			end
			S_SA1_GO: begin c_start = 1'b1; c_angle = a1_q; end
			S_SA2_GO: begin c_start = 1'b1; c_angle = q2_q - a1_q; end
			S_U_GO: begin
				d_start = 1'b1; d_num = NW'(sa1_q) * NW'(ca2_q); d_den = 36'(sv_q);
			end
			S_V_GO: begin
				d_start = 1'b1; d_num = NW'(sa1_q) * NW'(sa2_q); d_den = 36'(sv_q);
			end
			S_T_DIV: begin
				d_start = 1'b0;
			end
			default: ;
		endcase
		if (st_q == S_V && d_done) begin
			d_start = 1'b1;
			d_num = NW'(signed'({1'b0, k_q})) <<< 30;
			d_den = 36'(signed'({1'b0, steps_q}));
		end
	end

	// Multiply-accumulate: each product is built from five slices of its Q30 factor, four
	// of 16 bits and a top one of 8 bits that carries the sign, one slice per cycle and axis.
	logic signed [NW-1:0] one_m_u, one_m_t, neg_v;
	logic signed [CW-1:0] mx_c, my_c, mz_c;
	logic signed [NW-1:0] fx_c, fy_c, fz_c;
	logic signed [16:0] sx_c, sy_c, sz_c;
	logic signed [CW+16:0] px_part, py_part, pz_part;
	logic signed [PW-1:0] px_mul, py_mul, pz_mul;
	assign one_m_u = NW'(bat_pkg::ONE_Q30) - u_q;
	assign one_m_t = NW'(bat_pkg::ONE_Q30) - t_q;
	assign neg_v   = -v_q;

	function automatic logic signed [16:0] slice_of(input logic signed [NW-1:0] f,
	                                                input logic [2:0] i);
		begin
			case (i)
				3'd0: slice_of = {1'b0, f[15:0]};
				3'd1: slice_of = {1'b0, f[31:16]};
				3'd2: slice_of = {1'b0, f[47:32]};
				3'd3: slice_of = {1'b0, f[63:48]};
				3'd4: slice_of = {{9{f[NW-1]}}, f[71:64]};
				default: slice_of = '0;
			endcase
		end
	endfunction

	always_comb begin
		mx_c = '0; my_c = '0; mz_c = '0;
		fx_c = '0; fy_c = '0; fz_c = '0;
		case (mac_q)
			2'd0: begin
				mx_c = x0_q; fx_c = one_m_u;
				my_c = y0_q; fy_c = one_m_u;
				mz_c = z0_q; fz_c = one_m_t;
			end
			2'd1: begin
				mx_c = x1_q; fx_c = u_q;
				my_c = y1_q; fy_c = u_q;
				mz_c = z1_q; fz_c = t_q;
			end
			2'd2: begin
				mx_c = y0_q; fx_c = v_q;
				my_c = x1_q; fy_c = v_q;
			end
			2'd3: begin
				mx_c = y1_q; fx_c = neg_v;
				my_c = x0_q; fy_c = neg_v;
			end
			default: ;
		endcase
	end

	assign sx_c = slice_of(fx_c, slice_q);
	assign sy_c = slice_of(fy_c, slice_q);
	assign sz_c = slice_of(fz_c, slice_q);
	assign px_part = (CW+17)'(mx_c) * (CW+17)'(sx_c);
	assign py_part = (CW+17)'(my_c) * (CW+17)'(sy_c);
	assign pz_part = (CW+17)'(mz_c) * (CW+17)'(sz_c);
	assign px_mul = PW'(px_part) <<< {slice_q, 4'b0000};
	assign py_mul = PW'(py_part) <<< {slice_q, 4'b0000};
	assign pz_mul = PW'(pz_part) <<< {slice_q, 4'b0000};

	function automatic logic signed [CW-1:0] to_coord(input logic signed [PW-1:0] a);
		logic signed [PW-1:0] r;
		begin
			r = (a + (PW'(1) <<< 29)) >>> 30;
			if (r > (PW'(1) <<< (CW - 1)) - PW'(1))
				to_coord = {1'b0, {(CW-1){1'b1}}};
			else if (r < -(PW'(1) <<< (CW - 1)))
				to_coord = {1'b1, {(CW-1){1'b0}}};
			else
				to_coord = r[CW-1:0];
		end
	endfunction

	logic signed [bat_pkg::ANG_W+1:0] step_c, cnt_c;
	assign step_c = (STEP_ANG < 1) ? 36'sd1 : 36'(STEP_ANG);
	assign cnt_c  = (mag_q + step_c - 36'sd1);

	assign in.ready   = (st_q == S_IDLE) && !ovalid_q;
	assign out.valid  = ovalid_q;
	assign out.ox     = ox_q;
	assign out.oy     = oy_q;
	assign out.oz     = oz_q;
	assign out.run_end = oend_q;

	logic [5:0] steps_div;
	always_comb begin
		// Small search for ceil(mag/step); mag tops out below 2*pi.
		steps_div = 6'd0;
		for (int j = 1; j <= bat_pkg::MAX_STEPS; j++) begin
			if (cnt_c >= 36'(j) * step_c) steps_div = 6'(j);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			have_prev_q <= 1'b0;
			ovalid_q <= 1'b0;
			oend_q <= 1'b0;
			close_q <= 1'b0;
			prev_x_q <= '0; prev_y_q <= '0; prev_z_q <= '0; prev_bend_q <= '0;
			first_x_q <= '0; first_y_q <= '0; first_z_q <= '0;
			x0_q <= '0; y0_q <= '0; z0_q <= '0; x1_q <= '0; y1_q <= '0; z1_q <= '0;
			bend_q <= '0; q2_q <= '0; a1_q <= '0; mag_q <= '0;
			sv_q <= '0; sa1_q <= '0; ca2_q <= '0; sa2_q <= '0;
			u_q <= '0; v_q <= '0; t_q <= '0;
			acc_x_q <= '0; acc_y_q <= '0; acc_z_q <= '0;
			ox_q <= '0; oy_q <= '0; oz_q <= '0;
			k_q <= '0; steps_q <= '0; mac_q <= '0; slice_q <= '0;
		end else begin
			if (ovalid_q && out.ready) ovalid_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (in.valid && in.ready) begin
						x0_q <= prev_x_q; y0_q <= prev_y_q; z0_q <= prev_z_q;
						bend_q <= prev_bend_q;
						close_q <= in.mode;
						if (in.mode) begin
							x1_q <= first_x_q; y1_q <= first_y_q; z1_q <= first_z_q;
							if (have_prev_q) begin
								have_prev_q <= 1'b0;
								if (prev_bend_q != 0 && !(prev_x_q == first_x_q &&
									prev_y_q == first_y_q))
									st_q <= S_ATAN_GO;
							end
						end else begin
							x1_q <= in.px; y1_q <= in.py; z1_q <= in.pz;
							prev_x_q <= in.px; prev_y_q <= in.py; prev_z_q <= in.pz;
							prev_bend_q <= in.bend;
							have_prev_q <= 1'b1;
							if (in.start_req || !have_prev_q) begin
								first_x_q <= in.px; first_y_q <= in.py; first_z_q <= in.pz;
								st_q <= S_VTX;
							end else if (prev_bend_q != 0 && !(prev_x_q == in.px &&
								prev_y_q == in.py)) begin
								st_q <= S_ATAN_GO;
							end else begin
								st_q <= S_VTX;
							end
						end
					end
				end
				S_ATAN_GO: st_q <= S_ATAN;
				S_ATAN: if (c_done) begin
					q2_q <= c_z <<< 1;
					mag_q <= (c_z < 0) ? -(36'(c_z) <<< 2) : (36'(c_z) <<< 2);
					st_q <= S_SIN2_GO;
				end
				S_SIN2_GO: st_q <= S_SIN2;
				S_SIN2: if (c_done) begin
					sv_q <= c_sin;
					st_q <= (c_sin == 0) ? (close_q ? S_IDLE : S_VTX) : S_CNT;
				end
				S_CNT: begin
					steps_q <= (steps_div < 6'd2) ? 6'd2 : steps_div;
					k_q <= 6'd1;
					st_q <= S_PT_GO;
				end
				S_PT_GO: st_q <= S_A1_DIV;
				S_A1_DIV: if (d_done) begin
					a1_q <= bat_pkg::ang_t'(d_quo);
					st_q <= S_SA1_GO;
				end
				S_SA1_GO: st_q <= S_SA1;
				S_SA1: if (c_done) begin sa1_q <= c_sin; st_q <= S_SA2_GO; end
				S_SA2_GO: st_q <= S_SA2;
				S_SA2: if (c_done) begin
					sa2_q <= c_sin; ca2_q <= c_cos; st_q <= S_U_GO;
				end
				S_U_GO: st_q <= S_U;
				S_U: if (d_done) begin u_q <= d_quo; st_q <= S_V_GO; end
				S_V_GO: st_q <= S_V;
				S_V: if (d_done) begin v_q <= -d_quo; st_q <= S_T_DIV; end
				S_T_DIV: if (d_done) begin
					t_q <= d_quo;
					acc_x_q <= '0; acc_y_q <= '0; acc_z_q <= '0;
					mac_q <= 2'd0;
					slice_q <= 3'd0;
					st_q <= S_MAC;
				end
				S_MAC: begin
					acc_x_q <= acc_x_q + px_mul;
					acc_y_q <= acc_y_q + py_mul;
					acc_z_q <= acc_z_q + pz_mul;
					if (slice_q == 3'd4) begin
						slice_q <= 3'd0;
						mac_q <= mac_q + 2'd1;
						if (mac_q == 2'd3) st_q <= S_EMIT;
					end else begin
						slice_q <= slice_q + 3'd1;
					end
				end
				S_EMIT: if (!ovalid_q) begin
					ox_q <= to_coord(acc_x_q);
					oy_q <= to_coord(acc_y_q);
					oz_q <= to_coord(acc_z_q);
					ovalid_q <= 1'b1;
					oend_q <= close_q && (k_q == steps_q - 6'd1);
					if (k_q == steps_q - 6'd1) begin
						st_q <= close_q ? S_IDLE : S_VTX;
					end else begin
						k_q <= k_q + 6'd1;
						st_q <= S_PT_GO;
					end
				end
				S_VTX: if (!ovalid_q) begin
					ox_q <= x1_q; oy_q <= y1_q; oz_q <= z1_q;
					oend_q <= 1'b1;
					ovalid_q <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- hw/rtl/bat_cordic.sv -----
// Iterative CORDIC unit: one micro-rotation per cycle, vectoring or rotation.
`timescale 1ns / 1ps
module bat_cordic (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  bat_pkg::cordic_mode_t mode,
	input  logic signed [23:0]   bend,
	input  bat_pkg::ang_t        angle,
	output logic                 done,
	output bat_pkg::ang_t        z_out,
	output bat_pkg::trig_t       sin_out,
	output bat_pkg::trig_t       cos_out
);
	// The vectoring x grows to about 2^48, so the datapath is 50 bits.
	localparam int DW = 50;
	logic signed [DW-1:0] x_q, y_q;
	bat_pkg::ang_t z_q;
	logic [4:0] it_q;
	logic busy_q, flip_q;
	bat_pkg::cordic_mode_t mode_q;
	logic dir;
	logic signed [DW-1:0] xs, ys;
	bat_pkg::ang_t half_pi, a_fold;
	logic fold_hi, fold_lo;

	assign half_pi = bat_pkg::ang_t'(bat_pkg::PI_Q30 >>> 1);
	assign fold_hi = angle > half_pi;
	assign fold_lo = angle < -half_pi;
	always_comb begin
		if (fold_hi) begin
			a_fold = angle - bat_pkg::ang_t'(bat_pkg::PI_Q30);
		end else if (fold_lo) begin
			a_fold = angle + bat_pkg::ang_t'(bat_pkg::PI_Q30);
		end else begin
			a_fold = angle;
		end
	end

	assign xs = x_q >>> it_q;
	assign ys = y_q >>> it_q;
	// In vectoring mode the sign of y steers; in rotation mode the residual angle does.
	assign dir = (mode_q == bat_pkg::CORDIC_VECTOR) ? (y_q >= 0) : (z_q >= 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			it_q   <= '0;
			flip_q <= 1'b0;
			mode_q <= bat_pkg::CORDIC_VECTOR;
			x_q <= '0; y_q <= '0; z_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				it_q   <= '0;
				mode_q <= mode;
				if (mode == bat_pkg::CORDIC_VECTOR) begin
					x_q    <= DW'(64'sd1 <<< 40);
					y_q    <= DW'(bend) <<< 24;
					z_q    <= '0;
					flip_q <= 1'b0;
				end else begin
					x_q    <= DW'(bat_pkg::GAIN_Q30);
					y_q    <= '0;
					z_q    <= a_fold;
					flip_q <= fold_hi | fold_lo;
				end
			end else if (busy_q) begin
				if (mode_q == bat_pkg::CORDIC_VECTOR) begin
					if (dir) begin
						x_q <= x_q + ys; y_q <= y_q - xs;
						z_q <= z_q + bat_pkg::atan_tab(it_q);
					end else begin
						x_q <= x_q - ys; y_q <= y_q + xs;
						z_q <= z_q - bat_pkg::atan_tab(it_q);
					end
				end else begin
					if (dir) begin
						x_q <= x_q - ys; y_q <= y_q + xs;
						z_q <= z_q - bat_pkg::atan_tab(it_q);
					end else begin
						x_q <= x_q + ys; y_q <= y_q - xs;
						z_q <= z_q + bat_pkg::atan_tab(it_q);
					end
				end
				if (it_q == 5'(bat_pkg::ITERS - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end else begin
					it_q <= it_q + 5'd1;
				end
			end
		end
	end

	assign z_out   = z_q;
	assign sin_out = flip_q ? -bat_pkg::trig_t'(y_q) : bat_pkg::trig_t'(y_q);
	assign cos_out = flip_q ? -bat_pkg::trig_t'(x_q) : bat_pkg::trig_t'(x_q);
endmodule

// ----- hw/rtl/bat_divider.sv -----
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
module bat_divider #(
	parameter int NW = 72,
	parameter int DW = 36
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [NW-1:0] num,
	input  logic signed [DW-1:0] den,
	output logic                 done,
	output logic signed [NW-1:0] quo
);
	localparam int CW = $clog2(NW + 1);
	logic [NW-1:0] q_q;
	logic [DW:0] r_q;
	logic [DW-1:0] d_q;
	logic neg_q, busy_q;
	logic [CW-1:0] cnt_q;
	logic [DW:0] r_sh, r_sub;

	assign r_sh  = {r_q[DW-1:0], q_q[NW-1]};
	assign r_sub = r_sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
			neg_q  <= 1'b0;
			q_q <= '0; r_q <= '0; d_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
				q_q    <= num[NW-1] ? NW'(-num) : NW'(num);
				d_q    <= den[DW-1] ? DW'(-den) : DW'(den);
				r_q    <= '0;
				neg_q  <= num[NW-1] ^ den[DW-1];
			end else if (busy_q) begin
				if (!r_sub[DW]) begin
					r_q <= r_sub;
					q_q <= {q_q[NW-2:0], 1'b1};
				end else begin
					r_q <= r_sh;
					q_q <= {q_q[NW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign quo = neg_q ? -NW'(q_q) : NW'(q_q);
endmodule

// ----- hw/rtl/bat_checker.sv -----
// Port-level assertions for the tessellator, bound to the top level.
`timescale 1ns / 1ps
module bat_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_run_end
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output request dropped while stalled");
	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while a point waits");
	a_end_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_run_end))
		else $error("run_end changed under stall");
endmodule

bind bulge_arc_tessellator bat_checker u_bat_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in.valid), .in_ready(in.ready),
	.out_valid(out.valid), .out_ready(out.ready), .out_run_end(out.run_end)
);

// ----- verif/tb_top.sv -----
// Self-checking testbench for the bulge arc tessellator, with a scoreboard that predicts every point.
`timescale 1ns / 1ps
module tb_top;

	localparam int  CW         = 48;
	localparam bit  VERTEX     = 1'b0;
	localparam bit  CLOSE      = 1'b1;
	localparam int  STEP_DEG   = 10;
	localparam int  WATCH_MAX  = 40000;
	localparam int  N_RANDOM   = 440;
	localparam int  QUIET_TAIL = 60;

	typedef struct {
		bit      mode;
		bit      start;
		longint  x, y, z;
		longint  bend;
	} vertex_t;

	typedef struct {
		logic [CW-1:0] x, y, z;
		bit            last;
	} point_t;

	class bat_scoreboard;
		longint  atan_q30[bat_pkg::ITERS];
		longint  pi_q30;
		longint  last_x, last_y, last_z, last_bend, head_x, head_y, head_z;
		bit      open;
		point_t  points[$];
		int      mismatches;

		function new();
			longint unsigned quarter;
			quarter = inv_atan_q60(2) + inv_atan_q60(3);
			atan_q30[0] = longint'((quarter + (64'd1 << 29)) >> 30);
			for (int i = 1; i < bat_pkg::ITERS; i++)
				atan_q30[i] = longint'((inv_atan_q60(64'd1 << i) + (64'd1 << 29)) >> 30);
			pi_q30 = longint'((4 * quarter + (64'd1 << 29)) >> 30);
			open = 0;
			mismatches = 0;
		endfunction

		// Taylor series of atan(1/n) in Q60, truncating at each term.
		function longint unsigned inv_atan_q60(longint unsigned n);
			longint unsigned p, sum, k, term;
			p = (64'd1 << 60) / n;
			sum = 0;
			k = 0;
			while (p != 0) begin
				term = p / (2 * k + 1);
				if (k[0]) sum = sum - term; else sum = sum + term;
				p = p / (n * n);
				k++;
			end
			return sum;
		endfunction

		function void rotate(longint a, output longint s, output longint c);
			longint x, y, xn, half_pi;
			bit flip;
			x = 652032874;
			y = 0;
			half_pi = pi_q30 / 2;
			flip = 0;
			if (a > half_pi) begin
				a -= pi_q30;
				flip = 1;
			end else if (a < -half_pi) begin
				a += pi_q30;
				flip = 1;
			end
			for (int i = 0; i < bat_pkg::ITERS; i++) begin
				if (a >= 0) begin
					xn = x - (y >>> i);
					y = y + (x >>> i);
					a -= atan_q30[i];
				end else begin
					xn = x + (y >>> i);
					y = y - (x >>> i);
					a += atan_q30[i];
				end
				x = xn;
			end
			s = flip ? -y : y;
			c = flip ? -x : x;
		endfunction

		function longint bulge_angle(longint b);
			longint x, y, z, xn;
			x = 64'sd1 << 40;
			y = b * (64'sd1 << 24);
			z = 0;
			for (int i = 0; i < bat_pkg::ITERS; i++) begin
				if (y >= 0) begin
					xn = x + (y >>> i);
					y = y - (x >>> i);
					z += atan_q30[i];
				end else begin
					xn = x - (y >>> i);
					y = y + (x >>> i);
					z -= atan_q30[i];
				end
				x = xn;
			end
			return z;
		endfunction

		function logic signed [127:0] wmul(longint a, longint b);
			logic signed [127:0] ea, eb;
			ea = a;
			eb = b;
			return ea * eb;
		endfunction

		// Round half up from Q46 to Q16 and clamp to the coordinate range.
		function logic [CW-1:0] to_coord(logic signed [127:0] v);
			logic signed [127:0] hi, lo;
			hi = (128'sd1 <<< (CW - 1)) - 1;
			lo = -hi - 1;
			v = (v + (128'sd1 <<< 29)) >>> 30;
			if (v > hi) v = hi;
			if (v < lo) v = lo;
			return v[CW-1:0];
		endfunction

		function void arc(longint x0, longint y0, longint z0, longint x1, longint y1,
		                  longint z1, longint b, bit mark_last);
			longint q, mag, step, steps, s2q, cv, sa1, sa2, ca2, a1, u, v, t;
			point_t p;
			if (b == 0 || (x0 == x1 && y0 == y1)) return;
			q = bulge_angle(b);
			rotate(2 * q, s2q, cv);
			if (s2q == 0) return;
			mag = 4 * (q < 0 ? -q : q);
			step = (STEP_DEG * pi_q30 + 90) / 180;
			if (step < 1) step = 1;
			steps = (mag + step - 1) / step;
			if (steps < 2) steps = 2;
			if (steps > bat_pkg::MAX_STEPS) steps = bat_pkg::MAX_STEPS;
			for (longint k = 1; k < steps; k++) begin
				a1 = (2 * q * k) / steps;
				rotate(a1, sa1, cv);
				rotate(2 * q - a1, sa2, ca2);
				u = (sa1 * ca2) / s2q;
				v = -((sa1 * sa2) / s2q);
				t = (k <<< 30) / steps;
				p.x = to_coord(wmul(x0, (64'sd1 << 30) - u) + wmul(x1, u)
				               + wmul(y0, v) + wmul(y1, -v));
				p.y = to_coord(wmul(y0, (64'sd1 << 30) - u) + wmul(y1, u)
				               + wmul(x1, v) + wmul(x0, -v));
				p.z = to_coord(wmul(z0, (64'sd1 << 30) - t) + wmul(z1, t));
				p.last = mark_last && (k == steps - 1);
				points.insert(points.size(), p);
			end
		endfunction

		function void note(vertex_t r);
			point_t p;
			if (r.mode == CLOSE) begin
				if (open) arc(last_x, last_y, last_z, head_x, head_y, head_z, last_bend, 1);
				open = 0;
				return;
			end
			if (r.start || !open) begin
				head_x = r.x;
				head_y = r.y;
				head_z = r.z;
			end else begin
				arc(last_x, last_y, last_z, r.x, r.y, r.z, last_bend, 0);
			end
			p.x = r.x[CW-1:0];
			p.y = r.y[CW-1:0];
			p.z = r.z[CW-1:0];
			p.last = 1;
			points.insert(points.size(), p);
			last_x = r.x;
			last_y = r.y;
			last_z = r.z;
			last_bend = r.bend;
			open = 1;
		endfunction

		function void check(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z, logic last);
			point_t e;
			if (points.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected point x=%h y=%h z=%h run_end=%b", x, y, z, last);
				return;
			end
			e = points.pop_front();
			if (x !== e.x || y !== e.y || z !== e.z || last !== e.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"point mismatch: expected x=%h y=%h z=%h run_end=%b, ",
					          "got x=%h y=%h z=%h run_end=%b"},
					         e.x, e.y, e.z, e.last, x, y, z, last);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	bit   idle_on = 1;
	int   watch = 0;
	int   out_hold = 0;
	bat_scoreboard sb = new();

	bat_in_if  #(.COORD_WIDTH(CW)) in_if();
	bat_out_if #(.COORD_WIDTH(CW)) out_if();

	bulge_arc_tessellator #(.COORD_WIDTH(CW), .ARC_STEP_DEG(STEP_DEG)) dut (
		.clk(clk), .arst_n(arst_n), .in(in_if), .out(out_if)
	);

	always #6 clk = ~clk;

	initial begin
		in_if.valid = 0;
		in_if.mode = VERTEX;
		in_if.start_req = 0;
		in_if.px = 0;
		in_if.py = 0;
		in_if.pz = 0;
		in_if.bend = 0;
	end

	// Point sink: check every accepted point, stall in random bursts.
	always @(posedge clk) begin
		if (arst_n && out_if.valid && out_if.ready)
			sb.check(out_if.ox, out_if.oy, out_if.oz, out_if.run_end);
		if (out_hold > 0) begin
			out_hold <= out_hold - 1;
			out_if.ready <= 0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			out_hold <= $urandom_range(0, 6);
			out_if.ready <= 0;
		end else begin
			out_if.ready <= 1;
		end
	end

	always @(posedge clk) begin
		if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !arst_n)
			watch <= 0;
		else
			watch <= watch + 1;
		if (watch >= WATCH_MAX) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic longint rand_coord();
		longint v;
		case ($urandom_range(0, 9))
			0: v = {$urandom, $urandom};
			1: v = $urandom_range(0, 1) ? 64'sd140737488355327 : -64'sd140737488355328;
			2: v = longint'($signed(32'($urandom)));
			default: v = longint'($signed($urandom_range(0, 32'h07FF_FFFF))) - 64'sd67108864;
		endcase
		return (v <<< 16) >>> 16;
	endfunction

	function automatic longint rand_bend();
		longint v;
		case ($urandom_range(0, 9))
			0, 1, 2: v = 0;
			3: v = longint'($signed(24'($urandom)));
			4: v = $urandom_range(0, 1) ? 64'sd8388607 : -64'sd8388608;
			default: v = longint'($urandom_range(0, 65535)) - 32768;
		endcase
		return v;
	endfunction

	task automatic send(input bit mode, input bit start, input longint x, input longint y,
	                    input longint z, input longint b);
		vertex_t r;
		r.mode = mode;
		r.start = start;
		r.x = x;
		r.y = y;
		r.z = z;
		r.bend = b;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_if.valid <= 0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_if.valid <= 1;
		in_if.mode <= mode;
		in_if.start_req <= start;
		in_if.px <= x[CW-1:0];
		in_if.py <= y[CW-1:0];
		in_if.pz <= z[CW-1:0];
		in_if.bend <= b[23:0];
		do @(posedge clk); while (!(in_if.valid && in_if.ready));
		sb.note(r);
	endtask

	task automatic vertex(input bit start, input longint x, input longint y, input longint z,
	                      input longint b);
		send(VERTEX, start, x, y, z, b);
	endtask

	task automatic close_run();
		send(CLOSE, $urandom_range(0, 1), rand_coord(), rand_coord(), rand_coord(), rand_bend());
	endtask

	initial begin
		int sent, n;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed part.
		close_run();                                            // close with nothing open
		vertex(0, 64'sd65536, 64'sd0, 64'sd0, 64'sd65536);      // vertex with nothing open
		vertex(0, 64'sd0, 64'sd131072, 64'sd65536, 64'sd0);     // half circle
		vertex(0, 64'sd0, 64'sd131072, -64'sd65536, -64'sd30000); // zero chord
		vertex(0, -64'sd200000, 64'sd50000, 64'sd1000, 64'sd8388607); // arc with negative bulge
		vertex(0, 64'sd300000, -64'sd70000, 64'sd0, -64'sd8388608);   // max bulge
		vertex(0, -64'sd9000000, 64'sd4000000, 64'sd99999, 64'sd1);   // near full circle
		vertex(0, 64'sd10, 64'sd20, 64'sd30, -64'sd70000);      // tiny bulge
		close_run();                                            // close with an arc
		vertex(1, 64'sd140737488355327, 64'sd140737488355327, -64'sd140737488355328,
		       64'sd8388607);
		vertex(0, -64'sd140737488355328, -64'sd140737488355328, 64'sd140737488355327,
		       -64'sd8388608);
		vertex(1, -64'sd140737488355328, 64'sd140737488355327, 64'sd0, 64'sd0);
		vertex(0, 64'sd140737488355327, -64'sd140737488355328, 64'sd5, 64'sd65536);
		close_run();                                            // close with a half circle
		close_run();                                            // close after close
		vertex(1, 64'sd0, 64'sd0, 64'sd0, 64'sd20000);
		vertex(0, 64'sd655360, 64'sd0, 64'sd655360, 64'sd0);
		close_run();

		// Random polylines with some noise between them.
		sent = 0;
		while (sent < N_RANDOM) begin
			if (sent >= N_RANDOM - QUIET_TAIL) idle_on = 0;
			if ($urandom_range(0, 7) == 0) begin
				if ($urandom_range(0, 1)) close_run();
				else vertex($urandom_range(0, 1), rand_coord(), rand_coord(), rand_coord(),
				            rand_bend());
				sent++;
			end else begin
				n = $urandom_range(1, 6);
				vertex(1, rand_coord(), rand_coord(), rand_coord(), rand_bend());
				for (int i = 1; i < n; i++)
					vertex($urandom_range(0, 15) == 0, rand_coord(), rand_coord(), rand_coord(),
					       rand_bend());
				sent += n;
				if ($urandom_range(0, 1)) begin
					close_run();
					sent++;
				end
			end
		end
		in_if.valid <= 0;

		while (sb.points.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (sb.mismatches == 0 && sb.points.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
